[src/alignment_diff_column_expander_unit_defines.svh]
// Assertion macros for the alignment column expander.
`ifndef ALIGNMENT_DIFF_COLUMN_EXPANDER_UNIT_DEFINES_SVH
`define ALIGNMENT_DIFF_COLUMN_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ADCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ADCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/adce_pkg.sv]
// Types, constants and helper functions shared by the alignment column expander.
package adce_pkg;

  localparam int COL_W      = 7;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [2:0] DIFF_MATCH       = 3'd0;
  localparam logic [2:0] DIFF_TRANSITION  = 3'd1;
  localparam logic [2:0] DIFF_AMBIG       = 3'd2;
  localparam logic [2:0] DIFF_TRANSVERSION = 3'd3;
  localparam logic [2:0] DIFF_GAP         = 3'd4;

  localparam logic [1:0] REG_STRAND  = 2'd0;
  localparam logic [1:0] REG_QORIGIN = 2'd1;
  localparam logic [1:0] REG_SORIGIN = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] align_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         query_char;
    logic [7:0]         subject_char;
    logic [2:0]         diff_code;
    logic               line_end;
    logic signed [31:0] line_query_first;
    logic signed [31:0] line_query_last;
    logic signed [31:0] line_subject_first;
    logic signed [31:0] line_subject_last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_COLUMN,
    OP_AMEND,
    OP_FLUSH
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] query;
    logic [7:0] subject;
    logic [2:0] diff;
    logic       inc_query;
    logic       inc_subject;
  } op_item_t;

  typedef struct packed {
    logic        strand_minus;
    logic [30:0] query_origin;
    logic [30:0] subject_origin;
    logic        load_query;
    logic        load_subject;
  } cfg_state_t;

  function automatic logic is_ambig(input logic [7:0] c);
    logic r;
    case (c)
      "B", "D", "H", "V", "R", "Y", "K", "M", "S", "W", "N", "X": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] classify(input logic [7:0] q, input logic [7:0] s);
    logic [2:0] r;
    if ((q == "C" && s == "T") || (q == "T" && s == "C") ||
        (q == "A" && s == "G") || (q == "G" && s == "A")) begin
      r = DIFF_TRANSITION;
    end else if (is_ambig(q) || is_ambig(s)) begin
      r = DIFF_AMBIG;
    end else begin
      r = DIFF_TRANSVERSION;
    end
    return r;
  endfunction

endpackage

[src/adce_front.sv]
// Front end: accepts items, tracks mark state and turns characters and flushes into queue ops.
module adce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  adce_pkg::in_item_t in_data,
  input  logic              fifo_full,
  output logic              push,
  output adce_pkg::op_item_t push_item
);
  import adce_pkg::*;

  logic sub_pending;
  logic in_deletion;
  logic in_insertion;
  logic accept;
  logic [7:0] c;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign c        = in_data.align_char;

  always_comb begin
    push      = 1'b0;
    push_item = '{kind: OP_COLUMN, query: c, subject: c, diff: DIFF_MATCH,
                  inc_query: 1'b1, inc_subject: 1'b1};
    if (accept) begin
      if (in_data.req_type) begin
        push           = 1'b1;
        push_item.kind = OP_FLUSH;
      end else if (c != CH_SLASH && c != CH_DASH && c != CH_PLUS) begin
        push = 1'b1;
        if (sub_pending) begin
          push_item.kind = OP_AMEND;
        end else if (in_deletion) begin
          push_item.subject     = CH_DASH;
          push_item.diff        = DIFF_GAP;
          push_item.inc_subject = 1'b0;
        end else if (in_insertion) begin
          push_item.query     = CH_DASH;
          push_item.diff      = DIFF_GAP;
          push_item.inc_query = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_pending  <= 1'b0;
      in_deletion  <= 1'b0;
      in_insertion <= 1'b0;
    end else if (accept) begin
      if (in_data.req_type) begin
        sub_pending  <= 1'b0;
        in_deletion  <= 1'b0;
        in_insertion <= 1'b0;
      end else if (c == CH_SLASH) begin
        sub_pending <= 1'b1;
      end else if (c == CH_DASH) begin
        in_deletion <= !in_deletion;
      end else if (c == CH_PLUS) begin
        in_insertion <= !in_insertion;
      end else begin
        sub_pending <= 1'b0;
      end
    end
  end

endmodule

[src/adce_fifo.sv]
// Short op queue between the front and back ends.
module adce_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  adce_pkg::op_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output adce_pkg::op_item_t head_item
);
  import adce_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  op_item_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W:0]      count;

  assign full       = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_item;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/adce_back.sv]
// Back end: held column, line counters, coordinates and the output register.
module adce_back #(
  parameter int LINE_COLS = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  adce_pkg::cfg_state_t cfg,
  input  logic                 head_valid,
  input  adce_pkg::op_item_t   head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adce_pkg::out_item_t  out_data
);
  import adce_pkg::*;

  logic             held_valid;
  logic [7:0]       held_query;
  logic [7:0]       held_subject;
  logic [2:0]       held_diff;
  logic             held_line_end;
  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] query_bases;
  logic [COL_W-1:0] subject_bases;
  logic [31:0]      query_line_start;
  logic [31:0]      subject_line_start;

  logic             go;
  logic             emit;
  logic             end_flag;
  logic [31:0]      qb32;
  logic [31:0]      sb32;
  logic [31:0]      query_start_next;
  logic [31:0]      subject_start_next;
  logic [31:0]      subject_last;
  logic [COL_W-1:0] qb_base;
  logic [COL_W-1:0] sb_base;
  logic [COL_W-1:0] column_count_inc;
  out_item_t        emit_item;

  always_comb begin
    go       = head_valid && (!out_valid || !out_stall);
    pop      = go;
    emit     = go && held_valid && (head_item.kind == OP_COLUMN || head_item.kind == OP_FLUSH);
    end_flag = held_line_end || (head_item.kind == OP_FLUSH);
    qb32     = {{(32-COL_W){1'b0}}, query_bases};
    sb32     = {{(32-COL_W){1'b0}}, subject_bases};
    query_start_next = query_line_start + qb32;
    if (cfg.strand_minus) begin
      subject_start_next = subject_line_start - sb32;
      subject_last       = subject_start_next + 32'd1;
    end else begin
      subject_start_next = subject_line_start + sb32;
      subject_last       = subject_start_next - 32'd1;
    end
    qb_base          = (emit && end_flag) ? '0 : query_bases;
    sb_base          = (emit && end_flag) ? '0 : subject_bases;
    column_count_inc = column_count + 1'b1;

    emit_item.query_char         = held_query;
    emit_item.subject_char       = held_subject;
    emit_item.diff_code          = held_diff;
    emit_item.line_end           = end_flag;
    emit_item.line_query_first   = '0;
    emit_item.line_query_last    = '0;
    emit_item.line_subject_first = '0;
    emit_item.line_subject_last  = '0;
    if (end_flag) begin
      emit_item.line_query_first   = $signed(query_line_start);
      emit_item.line_query_last    = $signed(query_start_next - 32'd1);
      emit_item.line_subject_first = $signed(subject_line_start);
      emit_item.line_subject_last  = $signed(subject_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid         <= 1'b0;
      held_line_end      <= 1'b0;
      column_count       <= '0;
      query_bases        <= '0;
      subject_bases      <= '0;
      query_line_start   <= '0;
      subject_line_start <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg.load_query) begin
        query_line_start <= {1'b0, cfg.query_origin};
      end
      if (cfg.load_subject) begin
        subject_line_start <= {1'b0, cfg.subject_origin};
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_item;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        case (head_item.kind)
          OP_COLUMN: begin
            if (emit && end_flag) begin
              query_line_start   <= query_start_next;
              subject_line_start <= subject_start_next;
            end
            query_bases   <= qb_base + COL_W'(head_item.inc_query);
            subject_bases <= sb_base + COL_W'(head_item.inc_subject);
            held_valid    <= 1'b1;
            held_query    <= head_item.query;
            held_subject  <= head_item.subject;
            held_diff     <= head_item.diff;
            if (column_count_inc >= COL_W'(LINE_COLS)) begin
              held_line_end <= 1'b1;
              column_count  <= '0;
            end else begin
              held_line_end <= 1'b0;
              column_count  <= column_count_inc;
            end
          end
          OP_AMEND: begin
            if (held_valid) begin
              held_subject <= head_item.query;
              held_diff    <= classify(held_query, head_item.query);
            end
          end
          OP_FLUSH: begin
            held_valid         <= 1'b0;
            held_line_end      <= 1'b0;
            column_count       <= '0;
            query_bases        <= '0;
            subject_bases      <= '0;
            query_line_start   <= {1'b0, cfg.query_origin};
            subject_line_start <= {1'b0, cfg.subject_origin};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[src/alignment_diff_column_expander_unit.sv]
// Alignment column expander top level: config registers, front, op queue and back.
// Takes one alignment byte per cycle while the op queue is not full, and sustains one item
// per cycle while the output is not stalled. A column leaves only when the next column
// arrives or the alignment is flushed, because a following substitution may still amend it;
// the releasing item passes the op queue and the column then enters the output register.
// Marks ('/', '-', '+') are absorbed in the front end and never occupy the queue.
// The four-entry op queue lets input keep flowing while the output side stalls.
// Configuration writes are always ready and take effect the next cycle; writing an
// origin also reloads the matching line start. No clearing pass follows reset.
module alignment_diff_column_expander_unit #(
  parameter int LINE_COLS = 80
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  adce_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output adce_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import adce_pkg::*;
  `include "alignment_diff_column_expander_unit_defines.svh"

  cfg_state_t cfg;
  logic       fifo_full;
  logic       push;
  op_item_t   push_item;
  logic       pop;
  logic       head_valid;
  op_item_t   head_item;
  logic       cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg.load_query   <= cfg_write && (cfg_index == REG_QORIGIN);
      cfg.load_subject <= cfg_write && (cfg_index == REG_SORIGIN);
      if (cfg_write) begin
        case (cfg_index)
          REG_STRAND: begin
            cfg.strand_minus <= cfg_data[0];
          end
          REG_QORIGIN: begin
            cfg.query_origin <= cfg_data;
          end
          REG_SORIGIN: begin
            cfg.subject_origin <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  adce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  adce_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  adce_back #(
    .LINE_COLS (LINE_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `ADCE_ASSERT_NOW(a_coords_only_on_end, clk, rst, out_valid && !out_data.line_end, out_data.line_query_first == 0 && out_data.line_subject_last == 0, "coordinates set on a column that ends no line")
  `ADCE_ASSERT_NOW(a_gap_has_dash, clk, rst, out_valid && out_data.diff_code == DIFF_GAP, out_data.query_char == CH_DASH || out_data.subject_char == CH_DASH, "gap column without a dash")
  `ADCE_ASSERT_NOW(a_match_same_base, clk, rst, out_valid && out_data.diff_code == DIFF_MATCH, out_data.query_char == out_data.subject_char, "match column with differing bases")
  `ADCE_ASSERT_NEXT(a_no_pop_when_empty, clk, rst, !head_valid && !push, !pop, "op popped from an empty queue")

endmodule

[test/tb.sv]
// Testbench for the alignment column expander: directed and random alignment strings against a scoreboard.
`timescale 1ns / 100ps

module tb;
  import adce_pkg::*;

  localparam int LINE_COLS = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0] REG_NONE = 2'd3;

  class column_scoreboard;
    bit strand_minus;
    bit [30:0] q_origin;
    bit [30:0] s_origin;
    bit sub_pending;
    bit in_del;
    bit in_ins;
    bit held_valid;
    bit [7:0] held_q;
    bit [7:0] held_s;
    bit [2:0] held_diff;
    bit held_end;
    bit [6:0] col_cnt;
    bit [6:0] q_bases;
    bit [6:0] s_bases;
    bit [31:0] q_start;
    bit [31:0] s_start;
    out_item_t expected_q[$];
    int errors;

    function new();
      strand_minus = 1'b0;
      q_origin = '0;
      s_origin = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      sub_pending = 1'b0;
      in_del = 1'b0;
      in_ins = 1'b0;
      held_valid = 1'b0;
      held_q = '0;
      held_s = '0;
      held_diff = DIFF_MATCH;
      held_end = 1'b0;
      col_cnt = '0;
      q_bases = '0;
      s_bases = '0;
      q_start = {1'b0, q_origin};
      s_start = {1'b0, s_origin};
    endfunction

    function bit ambiguous_base(bit [7:0] c);
      string amb;
      amb = "BDHVRYKMSWNX";
      for (int i = 0; i < amb.len(); i++) begin
        if (amb[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit [2:0] sub_class(bit [7:0] q, bit [7:0] s);
      if ({q, s} inside {"CT", "TC", "AG", "GA"}) return DIFF_TRANSITION;
      if (ambiguous_base(q) || ambiguous_base(s)) return DIFF_AMBIG;
      return DIFF_TRANSVERSION;
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] v);
      case (idx)
        REG_STRAND: strand_minus = v[0];
        REG_QORIGIN: begin
          q_origin = v;
          q_start = {1'b0, v};
        end
        REG_SORIGIN: begin
          s_origin = v;
          s_start = {1'b0, v};
        end
        default: ;
      endcase
    endfunction

    function void emit_column(bit force_end);
      out_item_t e;
      bit end_flag;
      bit [31:0] s_last;
      end_flag = held_end | force_end;
      e = '0;
      e.query_char = held_q;
      e.subject_char = held_s;
      e.diff_code = held_diff;
      e.line_end = end_flag;
      if (end_flag) begin
        s_last = strand_minus ? s_start - s_bases + 32'd1 : s_start + s_bases - 32'd1;
        e.line_query_first = q_start;
        e.line_query_last = q_start + q_bases - 32'd1;
        e.line_subject_first = s_start;
        e.line_subject_last = s_last;
        q_start = q_start + q_bases;
        s_start = strand_minus ? s_start - s_bases : s_start + s_bases;
        q_bases = '0;
        s_bases = '0;
      end
      held_valid = 1'b0;
      held_end = 1'b0;
      expected_q.push_back(e);
    endfunction

    function void note_item(in_item_t it);
      bit [7:0] ch;
      bit [7:0] q;
      bit [7:0] s;
      bit [2:0] d;
      ch = it.align_char;
      if (it.req_type) begin
        if (held_valid) emit_column(1'b1);
        restart();
        return;
      end
      if (ch == CH_SLASH) begin
        sub_pending = 1'b1;
        return;
      end
      if (ch == CH_DASH) begin
        in_del = !in_del;
        return;
      end
      if (ch == CH_PLUS) begin
        in_ins = !in_ins;
        return;
      end
      if (sub_pending) begin
        sub_pending = 1'b0;
        if (held_valid) begin
          held_s = ch;
          held_diff = sub_class(held_q, ch);
        end
        return;
      end
      if (in_del) begin
        q = ch;
        s = CH_DASH;
        d = DIFF_GAP;
      end else if (in_ins) begin
        q = CH_DASH;
        s = ch;
        d = DIFF_GAP;
      end else begin
        q = ch;
        s = ch;
        d = DIFF_MATCH;
      end
      if (held_valid) emit_column(1'b0);
      if (!in_ins || in_del) q_bases = q_bases + 7'd1;
      if (!in_del) s_bases = s_bases + 7'd1;
      held_valid = 1'b1;
      held_q = q;
      held_s = s;
      held_diff = d;
      col_cnt = col_cnt + 7'd1;
      if (col_cnt >= LINE_COLS) begin
        held_end = 1'b1;
        col_cnt = '0;
      end else begin
        held_end = 1'b0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected column q=%h s=%h", got.query_char, got.subject_char));
        return;
      end
      e = expected_q.pop_front();
      cmp_field("query_char", got.query_char, e.query_char);
      cmp_field("subject_char", got.subject_char, e.subject_char);
      cmp_field("diff_code", got.diff_code, e.diff_code);
      cmp_field("line_end", got.line_end, e.line_end);
      cmp_field("line_query_first", got.line_query_first, e.line_query_first);
      cmp_field("line_query_last", got.line_query_last, e.line_query_last);
      cmp_field("line_subject_first", got.line_subject_first, e.line_subject_first);
      cmp_field("line_subject_last", got.line_subject_last, e.line_subject_last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_STRAND;
  logic [30:0] cfg_data = '0;

  column_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;
  int unsigned cycle_cnt = 0;

  alignment_diff_column_expander_unit #(
    .LINE_COLS(LINE_COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    sent++;
  endtask

  task automatic send_char(bit [7:0] c);
    in_item_t it;
    it.req_type = 1'b0;
    it.align_char = c;
    send_item(it);
  endtask

  task automatic send_flush();
    in_item_t it;
    it.req_type = 1'b1;
    it.align_char = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    stop_input();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(bit strand, bit [30:0] qo, bit [30:0] so, bit bad_index);
    cfg_write(REG_STRAND, {30'($urandom), strand});
    cfg_write(REG_QORIGIN, qo);
    cfg_write(REG_SORIGIN, so);
    if (bad_index) cfg_write(REG_NONE, 31'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [7:0] pick_base();
    string acgt = "ACGT";
    string amb = "BDHVRYKMSWNX";
    bit [7:0] c;
    int r;
    r = $urandom_range(99);
    if (r < 80) return acgt[$urandom_range(3)];
    if (r < 92) return amb[$urandom_range(11)];
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_SLASH || c == CH_DASH || c == CH_PLUS);
    return c;
  endfunction

  task automatic gen_random(int n);
    int target;
    int r;
    int k;
    bit paused;
    bit [7:0] mark;
    target = sent + n;
    paused = 1'b0;
    while (sent < target) begin
      // hold off once per phase until every column the scoreboard expects is out
      if (!paused && sent >= target - n / 2) begin
        stop_input();
        wait_results();
        paused = 1'b1;
      end
      if (sb.held_valid && sb.held_end && !sb.sub_pending && $urandom_range(1)) begin
        send_char(CH_SLASH);
        send_char(pick_base());
        continue;
      end
      r = $urandom_range(999);
      if (r < 560) begin
        send_char(pick_base());
      end else if (r < 680) begin
        send_char(CH_SLASH);
        send_char(pick_base());
      end else if (r < 840) begin
        mark = (r < 760) ? CH_DASH : CH_PLUS;
        send_char(mark);
        k = $urandom_range(6, 1);
        repeat (k) begin
          if ($urandom_range(6) == 0) send_char(CH_SLASH);
          send_char(pick_base());
        end
        send_char(mark);
      end else if (r < 852) begin
        send_flush();
      end else begin
        send_char(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    string dir;
    dir = "AC/TG/CA/N-AC-+G+-/T-";
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 27;
    recv_idle = 59;
    write_config(1'b0, 31'h7FFFFFFF, 31'h0, 1'b1);
    for (int i = 0; i < dir.len(); i++) send_char(dir[i]);
    send_char(8'h00);
    send_char(8'hFF);
    send_flush();
    // substitution with no column, then a flush with nothing held
    send_char(CH_SLASH);
    send_char("A");
    send_flush();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 59;
        recv_idle = 27;
      end
      if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p > 0) begin
        drain();
        case (p)
          1: write_config(1'b1, 31'h0, 31'h0, 1'b0);
          2: write_config(1'b1, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1);
          3: write_config(1'b0, 31'($urandom), 31'h7FFFFFFF, 1'b0);
          4: write_config(1'b1, 31'($urandom), 31'($urandom), 1'b0);
          default: write_config(1'b0, 31'h0, 31'($urandom), 1'b1);
        endcase
      end
      gen_random(140);
    end

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/adce_pkg.sv
src/adce_front.sv
src/adce_fifo.sv
src/adce_back.sv
src/alignment_diff_column_expander_unit.sv
test/tb.sv
